// ----- sv/connection_setup_state_machine_unit_assert.svh -----
// Assertion macros for the connection setup state machine unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CONNECTION_SETUP_STATE_MACHINE_UNIT_ASSERT_SVH
`define CONNECTION_SETUP_STATE_MACHINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// check that is switched off while reset is high
`define CSSM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cssm assertion failed");
// check that also runs through reset
`define CSSM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("cssm assertion failed during or after reset");
`else
`define CSSM_ASSERT(label, clk, rst, prop)
`define CSSM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- sv/cssm_pkg.sv -----
// Shared types and codes for the connection setup state machine unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package cssm_pkg;

   // field widths
   localparam int KIND_W   = 3;
   localparam int IDX_W    = 6;
   localparam int ID_W     = 32;
   localparam int REASON_W = 2;
   localparam int STATE_W  = 3;
   localparam int ACT_W    = 4;
   localparam int REJ_W    = 3;
   localparam int CSR_IDX_W = 2;

   // number of entries the index field can reach, and the default table size
   localparam int CONN_SLOTS   = 2 ** IDX_W;
   localparam int CONN_DEFAULT = 64;

   // connection states
   localparam logic [STATE_W-1:0] ST_DISC    = 3'd0;
   localparam logic [STATE_W-1:0] ST_RADDR   = 3'd1;
   localparam logic [STATE_W-1:0] ST_RROUTE  = 3'd2;
   localparam logic [STATE_W-1:0] ST_CONNING = 3'd3;
   localparam logic [STATE_W-1:0] ST_CONNED  = 3'd4;
   localparam logic [STATE_W-1:0] ST_DISCING = 3'd5;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_CONNECT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADDR_OK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ROUTE_OK = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ESTAB    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REQUEST  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd5;
   localparam logic [KIND_W-1:0] KIND_ERR_DISC = 3'd6;
   localparam logic [KIND_W-1:0] KIND_DESTROY  = 3'd7;

   // actions
   localparam logic [ACT_W-1:0] ACT_NONE          = 4'd0;
   localparam logic [ACT_W-1:0] ACT_RESOLVE_ADDR  = 4'd1;
   localparam logic [ACT_W-1:0] ACT_RESOLVE_ROUTE = 4'd2;
   localparam logic [ACT_W-1:0] ACT_CONNECT       = 4'd3;
   localparam logic [ACT_W-1:0] ACT_ACCEPT        = 4'd4;
   localparam logic [ACT_W-1:0] ACT_ACCEPT_SELF   = 4'd5;
   localparam logic [ACT_W-1:0] ACT_REJECT        = 4'd6;
   localparam logic [ACT_W-1:0] ACT_DISCONNECT    = 4'd7;
   localparam logic [ACT_W-1:0] ACT_FLUSH         = 4'd8;
   localparam logic [ACT_W-1:0] ACT_RELEASE       = 4'd9;

   // reject codes
   localparam logic [REJ_W-1:0] REJ_BAD_PARAM  = 3'd0;
   localparam logic [REJ_W-1:0] REJ_NO_TARGET  = 3'd1;
   localparam logic [REJ_W-1:0] REJ_ERROR      = 3'd2;
   localparam logic [REJ_W-1:0] REJ_CONNECTED  = 3'd3;
   localparam logic [REJ_W-1:0] REJ_CONNECTING = 3'd4;

   // peer reject reasons
   localparam logic [REASON_W-1:0] RSN_CONNECTED  = 2'd0;
   localparam logic [REASON_W-1:0] RSN_CONNECTING = 2'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ID  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_ID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHUTDOWN = 2'd2;

   // one event beat
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [IDX_W-1:0]    conn_index;
      logic [ID_W-1:0]     remote_node_id;
      logic [ID_W-1:0]     remote_process_id;
      logic                op_ok;
      logic                private_data_ok;
      logic                target_present;
      logic [REASON_W-1:0] remote_reason;
      logic                self_endpoint;
   } req_type;

   // one result beat
   typedef struct packed {
      logic [STATE_W-1:0] new_state;
      logic [ACT_W-1:0]   action;
      logic [REJ_W-1:0]   reject_code;
      logic               failed;
      logic               protocol_error;
   } rsp_type;

   // configuration seen by the decision logic
   typedef struct packed {
      logic [ID_W-1:0] local_node_id;
      logic [ID_W-1:0] local_process_id;
      logic            going_down;
   } cfg_type;

endpackage

`default_nettype wire

// ----- sv/cssm_table.sv -----
// Per-connection state table: memory with registered read, valid bits for reset.
// Depends on cssm_pkg; the read forwards a same-cycle write to the same entry.
`default_nettype none

module cssm_table
   import cssm_pkg::*;
#(
   parameter int DEPTH = CONN_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic [STATE_W-1:0] wr_data,
   output logic      [STATE_W-1:0] rd_state
);

   logic [STATE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]   vld_ff;
   logic [STATE_W-1:0] mem_rd_ff;
   logic               vld_rd_ff;
   logic               byp_ff;
   logic [STATE_W-1:0] byp_data_ff;

   // state memory write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // entry written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read, with the write of the same edge caught for forwarding
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_addr];
         vld_rd_ff   <= vld_ff[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   // never-written entries read as disconnected
   assign rd_state = byp_ff    ? byp_data_ff :
                     vld_rd_ff ? mem_rd_ff   : ST_DISC;

endmodule

`default_nettype wire

// ----- sv/cssm_decide.sv -----
// Next-state, action and reject decision for one connection event.
// Depends on cssm_pkg; purely combinational, between the input and result registers.
`default_nettype none

module cssm_decide
   import cssm_pkg::*;
(
   input  wire req_type            item,
   input  wire logic [STATE_W-1:0] cur_state,
   input  wire logic               in_range,
   input  wire cfg_type            cfg,
   output rsp_type                 rsp
);

   logic [2*ID_W-1:0]  rkey;
   logic [2*ID_W-1:0]  lkey;
   logic               sd;
   logic [STATE_W-1:0] ns;
   logic [ACT_W-1:0]   act;
   logic [REJ_W-1:0]   rej;
   logic               fail;
   logic               perr;

   // tie-break keys, node id in the upper half
   assign rkey = {item.remote_node_id, item.remote_process_id};
   assign lkey = {cfg.local_node_id, cfg.local_process_id};
   assign sd   = cfg.going_down;

   // event decode
   always_comb begin
      ns   = cur_state;
      act  = ACT_NONE;
      rej  = REJ_BAD_PARAM;
      fail = 1'b0;
      perr = 1'b0;
      unique case (item.kind)
         KIND_CONNECT: begin
            if (cur_state == ST_DISC) begin
               if (sd) begin
                  fail = 1'b1;
               end else begin
                  act = ACT_RESOLVE_ADDR;
                  if (item.op_ok) ns = ST_RADDR;
                  else fail = 1'b1;
               end
            end
         end
         KIND_ADDR_OK: begin
            if (!sd && cur_state == ST_RADDR) begin
               act = ACT_RESOLVE_ROUTE;
               if (item.op_ok) ns = ST_RROUTE;
               else begin
                  ns   = ST_DISC;
                  fail = 1'b1;
               end
            end
         end
         KIND_ROUTE_OK: begin
            if (!sd && cur_state == ST_RROUTE) begin
               act = ACT_CONNECT;
               if (item.op_ok) ns = ST_CONNING;
               else begin
                  ns   = ST_DISC;
                  fail = 1'b1;
               end
            end
         end
         KIND_ESTAB: begin
            if (!sd && !item.self_endpoint && cur_state == ST_CONNING) begin
               ns  = ST_CONNED;
               act = ACT_FLUSH;
            end
         end
         KIND_REQUEST: begin
            if (!item.private_data_ok) begin
               act = ACT_REJECT;
               rej = REJ_BAD_PARAM;
            end else if (!item.target_present) begin
               act = ACT_REJECT;
               rej = REJ_NO_TARGET;
            end else if (sd) begin
               act = ACT_REJECT;
               rej = REJ_ERROR;
            end else begin
               case (cur_state)
                  ST_CONNED: begin
                     act = ACT_REJECT;
                     rej = REJ_CONNECTED;
                  end
                  ST_DISCING: begin
                     perr = 1'b1;
                  end
                  ST_DISC: begin
                     act = ACT_ACCEPT;
                     if (item.op_ok) ns = ST_CONNING;
                     else begin
                        ns   = ST_DISC;
                        fail = 1'b1;
                     end
                  end
                  default: begin
                     // own attempt in flight: lower peer loses, equal is self connect
                     if (rkey < lkey) begin
                        act = ACT_REJECT;
                        rej = REJ_CONNECTING;
                     end else begin
                        act = (rkey > lkey) ? ACT_ACCEPT : ACT_ACCEPT_SELF;
                        if (item.op_ok) ns = ST_CONNING;
                        else begin
                           ns   = ST_DISC;
                           fail = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         KIND_REJECTED: begin
            if (!sd && item.private_data_ok &&
                item.remote_reason != RSN_CONNECTED &&
                item.remote_reason != RSN_CONNECTING) begin
               ns  = ST_DISC;
               act = ACT_RELEASE;
            end
         end
         KIND_ERR_DISC: begin
            if (!sd && cur_state != ST_DISC) begin
               ns  = ST_DISC;
               act = ACT_RELEASE;
            end
         end
         default: begin
            // destroy, unaffected by shutdown
            case (cur_state) inside
               ST_RROUTE, ST_CONNING, ST_CONNED: begin
                  ns  = ST_DISCING;
                  act = ACT_DISCONNECT;
               end
               ST_RADDR: begin
                  ns = ST_DISCING;
               end
               ST_DISCING: begin
                  perr = 1'b1;
               end
               default: begin
               end
            endcase
         end
      endcase
   end

   // an index beyond the table gives an all-zero result
   always_comb begin
      if (in_range) begin
         rsp.new_state      = ns;
         rsp.action         = act;
         rsp.reject_code    = rej;
         rsp.failed         = fail;
         rsp.protocol_error = perr;
      end else begin
         rsp = '0;
      end
   end

endmodule

`default_nettype wire

// ----- sv/connection_setup_state_machine_unit.sv -----
// Connection setup state machine unit: one event in, one result out, per beat.
// The block takes one event every clock cycle while results drain: the accepting edge
// registers the event and reads the entry's state from the table memory, and the edge that
// moves the event on writes the decided state back while loading the result register.
// A stalled result holds the event stage, and the input stalls only once both are full.
// Back-to-back events on the same entry see the freshly written state through a forwarding
// path around the table's registered read. The table is ready right after reset with no
// clearing pass; entries never written read as disconnected.
// Depends on cssm_pkg, cssm_table, cssm_decide and the assertion macro header.
`default_nettype none

`include "connection_setup_state_machine_unit_assert.svh"

module connection_setup_state_machine_unit
   import cssm_pkg::*;
#(
   parameter int CONNECTIONS = CONN_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // event channel
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // [5:0] conn_index, [37:6] remote_node_id, [69:38] remote_process_id,
   // [70] op_ok, [71] private_data_ok, [72] target_present,
   // [74:73] remote_reason, [75] self_endpoint, [79:76] zero
   input  wire logic [79:0]          req_tdata,
   // [2:0] kind
   input  wire logic [KIND_W-1:0]    req_tuser,
   // result channel
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // [2:0] new_state, [6:3] action, [9:7] reject_code, [10] failed,
   // [11] protocol_error, [15:12] zero
   output logic      [15:0]          rsp_tdata,
   // configuration write channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ID_W-1:0]      csr_data
);

   localparam int TBL_DEPTH = (CONNECTIONS < CONN_SLOTS) ? CONNECTIONS : CONN_SLOTS;
   localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
   localparam logic [31:0] CONN_LIM = 32'(CONNECTIONS);

   req_type            req_item;
   req_type            s1_item_ff;
   logic               s1_vld_ff;
   logic               s1_in_range;
   logic               req_acc;
   logic               advance;
   logic               tbl_wr_en;
   logic [STATE_W-1:0] tbl_state;
   rsp_type            dec_rsp;
   rsp_type            rsp_ff;
   logic               rsp_vld_ff;
   cfg_type            cfg_ff;

   // unpack the event beat
   assign req_item.kind              = req_tuser;
   assign req_item.conn_index        = req_tdata[5:0];
   assign req_item.remote_node_id    = req_tdata[37:6];
   assign req_item.remote_process_id = req_tdata[69:38];
   assign req_item.op_ok             = req_tdata[70];
   assign req_item.private_data_ok   = req_tdata[71];
   assign req_item.target_present    = req_tdata[72];
   assign req_item.remote_reason     = req_tdata[74:73];
   assign req_item.self_endpoint     = req_tdata[75];

   // configuration registers, to be written only while idle; the user must keep to this, the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NODE_ID:  cfg_ff.local_node_id    <= csr_data;
            CSR_PROC_ID:  cfg_ff.local_process_id <= csr_data;
            CSR_SHUTDOWN: cfg_ff.going_down       <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // flow control: stage one moves on when the result register is free or drains
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || advance;
   assign req_acc    = req_tvalid && req_tready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_tready) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_item_ff <= req_item;
      end
   end

   assign s1_in_range = (32'(s1_item_ff.conn_index) < CONN_LIM);
   assign tbl_wr_en   = s1_vld_ff && advance && s1_in_range;

   // state table
   cssm_table #(
      .DEPTH (TBL_DEPTH),
      .AW    (TBL_AW)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_acc),
      .rd_addr  (req_item.conn_index[TBL_AW-1:0]),
      .wr_en    (tbl_wr_en),
      .wr_addr  (s1_item_ff.conn_index[TBL_AW-1:0]),
      .wr_data  (dec_rsp.new_state),
      .rd_state (tbl_state)
   );

   // event decision
   cssm_decide u_decide (
      .item      (s1_item_ff),
      .cur_state (tbl_state),
      .in_range  (s1_in_range),
      .cfg       (cfg_ff),
      .rsp       (dec_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_vld_ff) begin
         rsp_ff <= dec_rsp;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.protocol_error, rsp_ff.failed, rsp_ff.reject_code,
                        rsp_ff.action, rsp_ff.new_state};

   // checks
   `CSSM_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (!rsp_tvalid && !s1_vld_ff))
   `CSSM_ASSERT(a_accept_fills_stage, clock, reset, req_acc |=> s1_vld_ff)
   `CSSM_ASSERT(a_perr_quiet, clock, reset,
      (rsp_tvalid && rsp_ff.protocol_error) |->
         (rsp_ff.new_state == ST_DISCING && rsp_ff.action == ACT_NONE))
   `CSSM_ASSERT(a_rej_only_reject, clock, reset,
      (rsp_tvalid && rsp_ff.reject_code != REJ_BAD_PARAM) |-> rsp_ff.action == ACT_REJECT)
   `CSSM_ASSERT(a_fail_disc, clock, reset,
      (rsp_tvalid && rsp_ff.failed) |-> rsp_ff.new_state == ST_DISC)

endmodule

`default_nettype wire
